### hw/rtl/hgps_pkg.sv
// Shared constants, types and fixed-point helpers for the HG direction sampler.
`default_nettype none

package hgps_pkg;

   // output and register fraction bits
   localparam int FRAC_BITS = 15;
   // internal fixed point: signed Q30
   localparam int Q_BITS    = 30;
   localparam int OUT_SHIFT = Q_BITS - FRAC_BITS;
   localparam int E1_SHIFT  = Q_BITS - 16;
   localparam int OFFSET_W  = 14;

   localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< Q_BITS;
   localparam logic signed [47:0] G_LIMIT = 48'sd1063004405;
   localparam logic [30:0]        HALF_PI = 31'd1686629713;

   // floor(n / (2^a * b)) as (n >> a) * ceil(2^36 / b) >> 36, exact for n < 2^30
   localparam int          RECIP_SHIFT = 36;
   localparam logic [34:0] RECIP_3  = 35'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
   localparam logic [34:0] RECIP_5  = 35'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);
   localparam logic [34:0] RECIP_7  = 35'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7);
   localparam logic [34:0] RECIP_9  = 35'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
   localparam logic [34:0] RECIP_15 = 35'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);
   localparam logic [34:0] RECIP_21 = 35'(((64'd1 << RECIP_SHIFT) + 64'd20) / 64'd21);
   localparam logic [34:0] RECIP_45 = 35'(((64'd1 << RECIP_SHIFT) + 64'd44) / 64'd45);

   // pipeline geometry
   localparam int DIV_STEPS      = Q_BITS;
   localparam int SQRT_STEPS     = 31;
   localparam int POL_STAGES     = 5 + DIV_STEPS + 2 + SQRT_STEPS;
   localparam int AZ_CORE_STAGES = 12;
   localparam int AZ_DELAY       = POL_STAGES - AZ_CORE_STAGES;
   localparam int BACK_STAGES    = POL_STAGES + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // azimuth quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   typedef struct packed {
      logic [15:0]         rand_polar;
      logic [1:0]          quad;
      logic                folded;
      logic [OFFSET_W-1:0] offset;
   } item_type;

   typedef struct packed {
      logic signed [31:0] cp;
      logic signed [31:0] sp;
   } azim_type;

   // signed Q30 product, round to nearest with ties up
   function automatic logic signed [35:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = a * b;
      p = p + (66'sd1 <<< (Q_BITS - 1));
      return $signed(p[65:Q_BITS]);
   endfunction

   // unsigned Q30 product, round to nearest
   function automatic logic [30:0] umul(input logic [29:0] a, input logic [30:0] b);
      logic [60:0] p;
      p = 61'(a) * 61'(b);
      p = p + (61'd1 << (Q_BITS - 1));
      return p[60:Q_BITS];
   endfunction

   function automatic logic [30:0] cdiv(input logic [30:0] n, input int sh,
                                        input logic [34:0] m);
      logic [30:0] ns;
      logic [65:0] p;
      ns = n >> sh;
      p  = 66'(ns) * 66'(m);
      return 31'(p >> RECIP_SHIFT);
   endfunction

   // register value to clamped Q30
   function automatic logic signed [31:0] g_to_q30(input logic [15:0] raw);
      logic signed [47:0] g;
      g = 48'($signed(raw)) <<< OUT_SHIFT;
      if (g > G_LIMIT) begin
         g = G_LIMIT;
      end else if (g < -G_LIMIT) begin
         g = -G_LIMIT;
      end
      return 32'(g);
   endfunction

   // Q30 to output format, round ties up, saturate
   function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
      logic signed [35:0] r;
      if (OUT_SHIFT > 0) begin
         r = (v + (36'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      end else begin
         r = v;
      end
      if (r > 36'sd32767) begin
         r = 36'sd32767;
      end else if (r < -36'sd32768) begin
         r = -36'sd32768;
      end
      return 16'(r);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hgps_front.sv
// Input register: takes request words and splits the azimuth into quadrant and fold.
`default_nettype none

module hgps_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [15:0]       req_rand_polar,
   input  wire logic [15:0]       req_rand_azimuth,
   input  wire logic              q_full,
   output logic                   push,
   output hgps_pkg::item_type     push_item
);

   logic                 valid_ff;
   hgps_pkg::item_type   item_ff;
   hgps_pkg::item_type   item_in;
   logic [hgps_pkg::OFFSET_W-1:0] r;

   always_comb begin
      r                  = req_rand_azimuth[hgps_pkg::OFFSET_W-1:0];
      item_in.rand_polar = req_rand_polar;
      item_in.quad       = req_rand_azimuth[15:hgps_pkg::OFFSET_W];
      // fold past an eighth of a turn onto the other octant
      item_in.folded     = r > (hgps_pkg::OFFSET_W'(1) << (hgps_pkg::OFFSET_W - 1));
      item_in.offset     = item_in.folded ? hgps_pkg::OFFSET_W'((15'd1 << hgps_pkg::OFFSET_W) - 15'(r))
                                          : r;
   end

   assign req_stall = valid_ff & q_full;
   assign push      = valid_ff & ~q_full;
   assign push_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hgps_queue.sv
// Short word queue between the front register and the back pipeline.
`default_nettype none

module hgps_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hgps_pkg::item_type push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    nonempty,
   output hgps_pkg::item_type      head
);

   hgps_pkg::item_type              mem_ff [hgps_pkg::QUEUE_DEPTH];
   logic [hgps_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [hgps_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [hgps_pkg::QCNT_W-1:0]     count_ff;
   logic                            do_push;
   logic                            do_pop;

   assign full     = count_ff == hgps_pkg::QCNT_W'(hgps_pkg::QUEUE_DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & nonempty;

   function automatic logic [hgps_pkg::QPTR_W-1:0] bump(input logic [hgps_pkg::QPTR_W-1:0] p);
      return (p == hgps_pkg::QPTR_W'(hgps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hgps_pkg::QCNT_W'(hgps_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

### hw/rtl/hgps_polar.sv
// Polar lane: HG cos(theta) by a bit-per-stage divider, then sin(theta) by a pipelined root.
`default_nettype none

module hgps_polar (
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic [15:0]        rand_polar,
   input  wire logic [15:0]        g_raw,
   output logic signed [31:0]      cost,
   output logic [30:0]             sint
);

   typedef struct packed {
      logic [31:0]                      r;
      logic [31:0]                      d;
      logic [hgps_pkg::DIV_STEPS-1:0]   q;
      logic                             neg;
      logic                             sat;
   } div_type;

   typedef struct packed {
      logic [60:0]        v;
      logic [61:0]        res;
      logic signed [31:0] cost;
   } sqrt_type;

   // stage 1
   logic signed [31:0] g1_ff, e1_1_ff, s1_ff, g2_1_ff, gs1_ff, e1sq1_ff;
   // stage 2
   logic signed [31:0] g3_2_ff, a2_ff, e1_2_ff;
   logic signed [35:0] sum2_ff;
   logic signed [32:0] den2_ff;
   // stage 3
   logic signed [31:0] t1_3_ff, e1_3_ff;
   logic signed [35:0] sum3_ff;
   logic [31:0]        dsq3_ff;
   // stage 4
   logic signed [35:0] num4_ff;
   logic [31:0]        dsq4_ff;

   div_type            div_ff [0:hgps_pkg::DIV_STEPS];
   logic signed [31:0] cost_c_ff;
   sqrt_type           sq_ff [0:hgps_pkg::SQRT_STEPS];

   logic signed [31:0] e1_w, s_w;
   logic signed [35:0] dsq_w, num_w, mag_w, cc_w, arg_w;
   logic signed [32:0] ge_arg;

   assign e1_w   = $signed(32'(rand_polar) << hgps_pkg::E1_SHIFT);
   assign s_w    = hgps_pkg::Q_ONE - (e1_w <<< 1);
   assign ge_arg = 33'(hgps_pkg::Q_ONE) - 33'(e1_1_ff) + 33'(e1sq1_ff);
   assign dsq_w  = hgps_pkg::qmul(den2_ff, den2_ff);
   assign num_w  = sum3_ff + (hgps_pkg::qmul(33'(t1_3_ff), 33'(e1_3_ff)) <<< 1);
   assign mag_w  = num4_ff[35] ? -num4_ff : num4_ff;
   assign cc_w   = hgps_pkg::qmul(33'(cost_c_ff), 33'(cost_c_ff));
   assign arg_w  = 36'(hgps_pkg::Q_ONE) - cc_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_ff    <= hgps_pkg::g_to_q30(g_raw);
         e1_1_ff  <= e1_w;
         s1_ff    <= s_w;
         g2_1_ff  <= 32'(hgps_pkg::qmul(33'(hgps_pkg::g_to_q30(g_raw)),
                                        33'(hgps_pkg::g_to_q30(g_raw))));
         gs1_ff   <= 32'(hgps_pkg::qmul(33'(hgps_pkg::g_to_q30(g_raw)), 33'(s_w)));
         e1sq1_ff <= 32'(hgps_pkg::qmul(33'(e1_w), 33'(e1_w)));

         g3_2_ff  <= 32'(hgps_pkg::qmul(33'(g2_1_ff), 33'(g1_ff)));
         a2_ff    <= e1_1_ff - hgps_pkg::Q_ONE;
         e1_2_ff  <= e1_1_ff;
         sum2_ff  <= 36'(s1_ff) + hgps_pkg::qmul(33'(g2_1_ff), 33'(s1_ff))
                     + (hgps_pkg::qmul(33'(g1_ff), ge_arg) <<< 1);
         den2_ff  <= 33'(hgps_pkg::Q_ONE) + 33'(gs1_ff);

         t1_3_ff  <= 32'(hgps_pkg::qmul(33'(g3_2_ff), 33'(a2_ff)));
         e1_3_ff  <= e1_2_ff;
         sum3_ff  <= sum2_ff;
         dsq3_ff  <= (dsq_w < 36'sd1) ? 32'd1 : dsq_w[31:0];

         num4_ff  <= num_w;
         dsq4_ff  <= dsq3_ff;

         // |num| >= den^2 puts the quotient at or past one
         div_ff[0].r   <= mag_w[31:0];
         div_ff[0].d   <= dsq4_ff;
         div_ff[0].q   <= '0;
         div_ff[0].neg <= num4_ff[35];
         div_ff[0].sat <= mag_w >= $signed({4'b0, dsq4_ff});
      end
   end

   for (genvar k = 1; k <= hgps_pkg::DIV_STEPS; k++) begin : g_div
      logic [32:0] r2;
      logic        take;
      assign r2   = {div_ff[k-1].r, 1'b0};
      assign take = r2 >= {1'b0, div_ff[k-1].d};
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k].r   <= take ? 32'(r2 - {1'b0, div_ff[k-1].d}) : r2[31:0];
            div_ff[k].d   <= div_ff[k-1].d;
            div_ff[k].q   <= {div_ff[k-1].q[hgps_pkg::DIV_STEPS-2:0], take};
            div_ff[k].neg <= div_ff[k-1].neg;
            div_ff[k].sat <= div_ff[k-1].sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (div_ff[hgps_pkg::DIV_STEPS].sat) begin
            cost_c_ff <= div_ff[hgps_pkg::DIV_STEPS].neg ? -hgps_pkg::Q_ONE : hgps_pkg::Q_ONE;
         end else if (div_ff[hgps_pkg::DIV_STEPS].neg) begin
            cost_c_ff <= -$signed(32'(div_ff[hgps_pkg::DIV_STEPS].q));
         end else begin
            cost_c_ff <= $signed(32'(div_ff[hgps_pkg::DIV_STEPS].q));
         end
         sq_ff[0].v    <= arg_w[35] ? '0 : {arg_w[30:0], 30'd0};
         sq_ff[0].res  <= '0;
         sq_ff[0].cost <= cost_c_ff;
      end
   end

   for (genvar i = 1; i <= hgps_pkg::SQRT_STEPS; i++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (62 - 2 * i);
      logic [61:0] trial;
      logic        take;
      assign trial = sq_ff[i-1].res + BIT;
      assign take  = {1'b0, sq_ff[i-1].v} >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[i].v    <= take ? 61'({1'b0, sq_ff[i-1].v} - trial) : sq_ff[i-1].v;
            sq_ff[i].res  <= take ? (sq_ff[i-1].res >> 1) + BIT : sq_ff[i-1].res >> 1;
            sq_ff[i].cost <= sq_ff[i-1].cost;
         end
      end
   end

   assign cost = sq_ff[hgps_pkg::SQRT_STEPS].cost;
   assign sint = sq_ff[hgps_pkg::SQRT_STEPS].res[30:0];

endmodule

`default_nettype wire

### hw/rtl/hgps_azim.sv
// Azimuth lane: Horner sin/cos of the folded angle, quadrant mapping, alignment delay.
`default_nettype none

module hgps_azim (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [1:0]                    quad,
   input  wire logic                          folded,
   input  wire logic [hgps_pkg::OFFSET_W-1:0] offset,
   output hgps_pkg::azim_type                 azim
);

   typedef struct packed {
      logic [1:0]  quad;
      logic        folded;
      logic [29:0] x;
      logic [29:0] x2;
   } carry_type;

   carry_type         carry_ff [1:11];
   logic [30:0]       sin_ff   [3:11];
   logic [30:0]       cos_ff   [3:11];
   hgps_pkg::azim_type dly_ff  [0:hgps_pkg::AZ_DELAY];
   logic [44:0]       angle;
   logic [30:0]       one;
   logic signed [31:0] c_w, s_w;
   hgps_pkg::azim_type sel_w;

   assign one   = 31'(hgps_pkg::Q_ONE);
   assign angle = 45'(offset) * 45'(hgps_pkg::HALF_PI);

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff[1].quad   <= quad;
         carry_ff[1].folded <= folded;
         carry_ff[1].x      <= 30'(angle >> hgps_pkg::OFFSET_W);
         carry_ff[1].x2     <= '0;
         carry_ff[2].quad   <= carry_ff[1].quad;
         carry_ff[2].folded <= carry_ff[1].folded;
         carry_ff[2].x      <= carry_ff[1].x;
         carry_ff[2].x2     <= 30'(hgps_pkg::umul(carry_ff[1].x, 31'(carry_ff[1].x)));
         for (int j = 3; j <= 11; j++) begin
            carry_ff[j] <= carry_ff[j-1];
         end

         // sine: 1 - x^2/72, then steps by 42, 20, 6, then times x
         sin_ff[3]  <= one - hgps_pkg::cdiv(31'(carry_ff[2].x2), 3, hgps_pkg::RECIP_9);
         sin_ff[4]  <= hgps_pkg::umul(carry_ff[3].x2, sin_ff[3]);
         sin_ff[5]  <= one - hgps_pkg::cdiv(sin_ff[4], 1, hgps_pkg::RECIP_21);
         sin_ff[6]  <= hgps_pkg::umul(carry_ff[5].x2, sin_ff[5]);
         sin_ff[7]  <= one - hgps_pkg::cdiv(sin_ff[6], 2, hgps_pkg::RECIP_5);
         sin_ff[8]  <= hgps_pkg::umul(carry_ff[7].x2, sin_ff[7]);
         sin_ff[9]  <= one - hgps_pkg::cdiv(sin_ff[8], 1, hgps_pkg::RECIP_3);
         sin_ff[10] <= hgps_pkg::umul(carry_ff[9].x, sin_ff[9]);
         sin_ff[11] <= sin_ff[10];

         // cosine: 1 - x^2/90, then steps by 56, 30, 12, 2
         cos_ff[3]  <= one - hgps_pkg::cdiv(31'(carry_ff[2].x2), 1, hgps_pkg::RECIP_45);
         cos_ff[4]  <= hgps_pkg::umul(carry_ff[3].x2, cos_ff[3]);
         cos_ff[5]  <= one - hgps_pkg::cdiv(cos_ff[4], 3, hgps_pkg::RECIP_7);
         cos_ff[6]  <= hgps_pkg::umul(carry_ff[5].x2, cos_ff[5]);
         cos_ff[7]  <= one - hgps_pkg::cdiv(cos_ff[6], 1, hgps_pkg::RECIP_15);
         cos_ff[8]  <= hgps_pkg::umul(carry_ff[7].x2, cos_ff[7]);
         cos_ff[9]  <= one - hgps_pkg::cdiv(cos_ff[8], 2, hgps_pkg::RECIP_3);
         cos_ff[10] <= hgps_pkg::umul(carry_ff[9].x2, cos_ff[9]);
         cos_ff[11] <= one - (cos_ff[10] >> 1);

         dly_ff[0] <= sel_w;
         for (int j = 1; j <= hgps_pkg::AZ_DELAY; j++) begin
            dly_ff[j] <= dly_ff[j-1];
         end
      end
   end

   always_comb begin
      c_w = carry_ff[11].folded ? $signed(32'(sin_ff[11])) : $signed(32'(cos_ff[11]));
      s_w = carry_ff[11].folded ? $signed(32'(cos_ff[11])) : $signed(32'(sin_ff[11]));
      case (carry_ff[11].quad)
         hgps_pkg::QUAD_0: begin
            sel_w.cp = c_w;
            sel_w.sp = s_w;
         end
         hgps_pkg::QUAD_1: begin
            sel_w.cp = -s_w;
            sel_w.sp = c_w;
         end
         hgps_pkg::QUAD_2: begin
            sel_w.cp = -c_w;
            sel_w.sp = -s_w;
         end
         default: begin
            sel_w.cp = s_w;
            sel_w.sp = -c_w;
         end
      endcase
   end

   assign azim = dly_ff[hgps_pkg::AZ_DELAY];

endmodule

`default_nettype wire

### hw/rtl/hg_phase_direction_sample_core.sv
// Henyey-Greenstein scattering direction sampler, top level.
//
// Request words carry two uniform 16-bit fractions (polar, azimuth); each word
// yields one response word with a unit direction (x, y, z) in Q1.15, z being
// cos(theta). Both channels use valid/stall: a word moves on an edge with
// valid high and stall low. csr_wr_en/csr_wr_data load the anisotropy g
// (signed Q1.15, reset 0); write it only while no words are in flight.
// Throughput: one word per cycle while no response is held. From request
// accept to response valid a word passes the input register, the
// queue, 69 back stages and the response register. The depth is set by the
// 30-stage divider for cos(theta) and the 31-stage square root, one result
// bit per stage. A held response freezes the whole back pipeline; the
// four-word queue keeps taking requests until it fills, then req_stall rises.
// Synchronous reset empties the queue and pipeline and clears g.
`default_nettype none

module hg_phase_direction_sample_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_rand_polar,
   input  wire logic [15:0]        req_rand_azimuth,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_dir_x,
   output logic signed [15:0]      rsp_dir_y,
   output logic signed [15:0]      rsp_dir_z,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);

   logic [15:0]                         g_ff;
   logic                                q_full, q_nonempty, push, adv;
   hgps_pkg::item_type                  push_item, head;
   logic [hgps_pkg::BACK_STAGES:1]      v_ff;
   logic signed [31:0]                  cost;
   logic [30:0]                         sint;
   hgps_pkg::azim_type                  azim;
   logic signed [35:0]                  px_ff, py_ff;
   logic signed [31:0]                  pz_ff;
   logic                                rsp_valid_ff;
   logic signed [15:0]                  dir_x_ff, dir_y_ff, dir_z_ff;

   assign adv = ~rsp_valid_ff | ~rsp_stall;

   hgps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rand_polar   (req_rand_polar),
      .req_rand_azimuth (req_rand_azimuth),
      .q_full           (q_full),
      .push             (push),
      .push_item        (push_item)
   );

   hgps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (adv),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .head      (head)
   );

   hgps_polar u_polar (
      .clock      (clock),
      .adv        (adv),
      .rand_polar (head.rand_polar),
      .g_raw      (g_ff),
      .cost       (cost),
      .sint       (sint)
   );

   hgps_azim u_azim (
      .clock  (clock),
      .adv    (adv),
      .quad   (head.quad),
      .folded (head.folded),
      .offset (head.offset),
      .azim   (azim)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff         <= '0;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            g_ff <= csr_wr_data;
         end
         if (adv) begin
            v_ff         <= {v_ff[hgps_pkg::BACK_STAGES-1:1], q_nonempty};
            rsp_valid_ff <= v_ff[hgps_pkg::BACK_STAGES];
         end
      end
      if (adv) begin
         px_ff    <= hgps_pkg::qmul(33'(azim.cp), $signed({2'b00, sint}));
         py_ff    <= hgps_pkg::qmul(33'(azim.sp), $signed({2'b00, sint}));
         pz_ff    <= cost;
         dir_x_ff <= hgps_pkg::to_out(px_ff);
         dir_y_ff <= hgps_pkg::to_out(py_ff);
         dir_z_ff <= hgps_pkg::to_out(36'(pz_ff));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dir_x = dir_x_ff;
   assign rsp_dir_y = dir_y_ff;
   assign rsp_dir_z = dir_z_ff;

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("back pipeline moved while frozen");

   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      (adv && q_nonempty) |=> v_ff[1])
      else $error("popped word lost at pipeline entry");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v_ff[hgps_pkg::BACK_STAGES]))
      else $error("response without a word in the last stage");

endmodule

`default_nettype wire

### bench/hg_phase_direction_sample_core_tb.sv
// Self-checking bench for the HG direction sampler: directed and random words, predicted directions, scoreboard.
`timescale 1ns / 1ps

module hg_phase_direction_sample_core_tb;

   typedef struct {
      logic [15:0] polar;
      logic [15:0] azim;
   } req_word_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } dir_word_type;

   localparam int  LATENCY = 71;
   localparam longint Q1 = 64'sd1 << 30;
   localparam longint G_MAX = 64'sd1063004405;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [15:0] req_rand_polar;
   logic [15:0] req_rand_azimuth;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_dir_x;
   logic signed [15:0] rsp_dir_y;
   logic signed [15:0] rsp_dir_z;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   req_word_type pending_words[$];
   dir_word_type expected_dirs[$];
   logic [15:0] g_shadow;
   int errors;
   int checked;
   int send_gap;
   int recv_gap;
   int hold_off;
   bit hold_go;
   bit hold_done;
   bit stim_done;

   hg_phase_direction_sample_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rand_polar(req_rand_polar), .req_rand_azimuth(req_rand_azimuth),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint qprod(longint a, longint b);
      return floor_shift(a * b + (64'sd1 << 29), 30);
   endfunction

   function automatic longint uprod(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] q30_to_q15(longint v);
      longint r;
      r = floor_shift(v + (64'sd1 << 14), 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // HG polar angle plus Taylor azimuth, all in Q30
   function automatic dir_word_type predict_direction(logic [15:0] graw, req_word_type w);
      dir_word_type d;
      longint g, e1, s, g2, g3, num, den, den2, cost, arg, sint;
      longint r, rr, x, x2, t, sn, cs, c, sv, cp, sp;
      bit folded;
      g = longint'($signed(graw)) <<< 15;
      if (g > G_MAX) g = G_MAX;
      if (g < -G_MAX) g = -G_MAX;
      e1 = longint'(w.polar) << 14;
      s = Q1 - 2 * e1;
      g2 = qprod(g, g);
      g3 = qprod(g2, g);
      num = s + 2 * qprod(qprod(g3, e1 - Q1), e1) + qprod(g2, s)
            + 2 * qprod(g, Q1 - e1 + qprod(e1, e1));
      den = Q1 + qprod(g, s);
      den2 = qprod(den, den);
      if (den2 < 1) den2 = 1;
      cost = (num * Q1) / den2;
      if (cost > Q1) cost = Q1;
      if (cost < -Q1) cost = -Q1;
      arg = Q1 - qprod(cost, cost);
      if (arg < 0) arg = 0;
      sint = int_sqrt(arg << 30);

      r = longint'(w.azim[13:0]);
      folded = r > 64'sd8192;
      rr = folded ? 64'sd16384 - r : r;
      x = (rr * HALF_PI_Q30) >>> 14;
      x2 = uprod(x, x);
      t = Q1 - x2 / 72;
      t = Q1 - uprod(x2, t) / 42;
      t = Q1 - uprod(x2, t) / 20;
      t = Q1 - uprod(x2, t) / 6;
      sn = uprod(x, t);
      t = Q1 - x2 / 90;
      t = Q1 - uprod(x2, t) / 56;
      t = Q1 - uprod(x2, t) / 30;
      t = Q1 - uprod(x2, t) / 12;
      cs = Q1 - uprod(x2, t) / 2;
      c = folded ? sn : cs;
      sv = folded ? cs : sn;
      case (w.azim[15:14])
         hgps_pkg::QUAD_0: begin cp = c;   sp = sv;  end
         hgps_pkg::QUAD_1: begin cp = -sv; sp = c;   end
         hgps_pkg::QUAD_2: begin cp = -c;  sp = -sv; end
         default: begin cp = sv; sp = -c; end
      endcase
      d.x = q30_to_q15(qprod(cp, sint));
      d.y = q30_to_q15(qprod(sp, sint));
      d.z = q30_to_q15(cost);
      return d;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         expected_dirs.push_back(predict_direction(g_shadow,
            '{polar: req_rand_polar, azim: req_rand_azimuth}));
         send_gap = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
         if (send_gap == 0 && pending_words.size() > 0) begin
            req_rand_polar <= pending_words[0].polar;
            req_rand_azimuth <= pending_words[0].azim;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_words.size() > 0) begin
            req_valid <= 1'b1;
            req_rand_polar <= pending_words[0].polar;
            req_rand_azimuth <= pending_words[0].azim;
            void'(pending_words.pop_front());
         end
      end
   end

   // long response hold, started once by the stimulus
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 0;
         hold_done <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (hold_go && !hold_done) begin
         hold_off <= 300;
         hold_done <= 1'b1;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                        rsp_dir_x, rsp_dir_y, rsp_dir_z);
               errors++;
            end else begin
               dir_word_type e;
               e = expected_dirs.pop_front();
               checked++;
               if (e.x !== rsp_dir_x)
                  begin $display("%0t: dir_x exp %0d got %0d", $time, e.x, rsp_dir_x); errors++; end
               if (e.y !== rsp_dir_y)
                  begin $display("%0t: dir_y exp %0d got %0d", $time, e.y, rsp_dir_y); errors++; end
               if (e.z !== rsp_dir_z)
                  begin $display("%0t: dir_z exp %0d got %0d", $time, e.z, rsp_dir_z); errors++; end
            end
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_word(logic [15:0] p, logic [15:0] a);
      pending_words.push_back('{polar: p, azim: a});
   endtask

   task automatic drain_and_set_g(logic [15:0] g);
      while (pending_words.size() > 0 || req_valid || expected_dirs.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      g_shadow = g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [15:0] g_set[7];
      int n;
      g_set = '{16'sd0, 16'sd32440, -16'sd32440, 16'sh7fff, 16'sh8000, 16'sd9830, -16'sd21000};
      errors = 0;
      checked = 0;
      hold_go = 1'b0;
      stim_done = 0;
      g_shadow = 16'd0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_rand_polar = 16'd0;
      req_rand_azimuth = 16'd0;
      csr_wr_en = 1'b0;
      csr_wr_data = 16'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of e1, quadrant and fold boundaries of e2
      foreach (g_set[k]) begin
         if (k > 0 && k < 3) begin
            drain_and_set_g(g_set[k]);
            queue_word(16'h0000, 16'h0000);
            queue_word(16'hffff, 16'hffff);
            queue_word(16'h8000, 16'h4000);
            queue_word(16'h0001, 16'h8000);
            queue_word(16'h7fff, 16'hc000);
            queue_word(16'haaaa, 16'h2000);
            queue_word(16'h5555, 16'h2001);
            queue_word(16'hfffe, 16'h1fff);
         end
      end
      // random phases across several g settings
      foreach (g_set[k]) begin
         drain_and_set_g(k == 0 ? 16'($urandom) : g_set[k]);
         n = 130;
         if (k == 3) hold_go = 1'b1;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               0: queue_word(16'($urandom_range(0, 15)), 16'($urandom));
               1: queue_word(16'(16'hffff - $urandom_range(0, 15)), 16'($urandom));
               default: queue_word(16'($urandom), 16'($urandom));
            endcase
         end
      end
      while (pending_words.size() > 0 || req_valid || expected_dirs.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d direction words over several anisotropy settings,", checked);
      $display("including the clamp limits and a long response stall.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
